// ===== rtl/chp_pkg.sv =====
package chp_pkg;

  // table geometry
  localparam int BUCKETS      = 16;
  localparam int POOL_ENTRIES = 256;
  localparam int VAL_W        = 31;
  localparam int BKT_W        = $clog2(BUCKETS);
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int PTR_W        = IDX_W + 1;
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_ENTRIES);

  // operation codes
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_SEARCH = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_MAX    = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC,
    S_INS_WR,
    S_WALK,
    S_CHECK,
    S_UNLINK,
    S_FREE,
    S_FIN
  } state_t;

endpackage

// ===== rtl/chp_ram.sv =====
module chp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/chained_hash_table_top.sv =====
// chained hash table of 31-bit values, 16 buckets, 256 pool entries
// input channel: kind, item_value with item_valid / item_stall; an item is
// taken when item_valid is high and item_stall low. item_stall is high while
// an item is being worked on.
// result channel: status, result_value with result_valid / result_stall;
// exactly one result per item, held in an output register until taken.
// per item, each chain node visited costs a pool memory read, then a compare:
//   insert: dispatch, a free-list pop when the slot comes from the free list,
//   then the write of the new entry; search walks the bucket's chain node by node;
//   delete adds the unlink and free-list push to a hit; max query walks all 16
//   buckets and every stored entry; clear and unused kinds go straight to the last state.
// the single port of the pool memory splits each node into read and compare.
// a new item is taken while a finished result still waits; its own result
// then waits in the last state until the result register is free.
// reset (rst, synchronous) empties the table at once: bucket heads and the
// free list go null and the fresh slot count to zero; no clearing pass.
module chained_hash_table_top
  import chp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [2:0]       kind,
  input  logic [VAL_W-1:0] item_value,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [1:0]       status,
  output logic [VAL_W-1:0] result_value
);

  state_t state, state_next;

  logic [2:0]       op;
  logic [VAL_W-1:0] val;
  logic [PTR_W-1:0] head [BUCKETS];
  logic [PTR_W-1:0] free_head, free_head_next;
  logic [PTR_W-1:0] fresh_count, fresh_count_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [PTR_W-1:0] prev, prev_next;
  logic [PTR_W-1:0] cur_link, cur_link_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic [BKT_W-1:0] bkt_k, bkt_k_next;
  logic             any, any_next;
  logic [VAL_W-1:0] best, best_next;
  logic [1:0]       stat, stat_next;
  logic [VAL_W-1:0] res, res_next;

  logic             head_we, head_clear;
  logic [BKT_W-1:0] head_waddr;
  logic [PTR_W-1:0] head_wdata;

  logic [IDX_W-1:0] mem_addr;
  logic             val_we, link_we;
  logic [VAL_W-1:0] val_rdata;
  logic [PTR_W-1:0] link_wdata, link_rdata;

  logic [BKT_W-1:0] bkt;
  logic             item_take, result_load;

  assign bkt        = val[BKT_W-1:0];
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;

  // pool memories
  chp_ram #(.WIDTH(VAL_W), .DEPTH(POOL_ENTRIES)) u_val_ram (
    .clk(clk), .addr(mem_addr), .we(val_we), .wdata(val), .rdata(val_rdata)
  );

  chp_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk(clk), .addr(mem_addr), .we(link_we), .wdata(link_wdata), .rdata(link_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (item_take) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (op)
          KIND_INSERT: begin
            if (free_head != NIL_PTR) state_next = S_ALLOC;
            else if (fresh_count != NIL_PTR) state_next = S_INS_WR;
            else state_next = S_FIN;
          end
          KIND_SEARCH, KIND_DELETE, KIND_MAX: state_next = S_WALK;
          default: state_next = S_FIN;
        endcase
      end
      S_ALLOC:    state_next = S_INS_WR;
      S_INS_WR:   state_next = S_FIN;
      S_WALK: begin
        if (ptr != NIL_PTR) state_next = S_CHECK;
        else if (op != KIND_MAX || bkt_k == BKT_W'(BUCKETS - 1)) state_next = S_FIN;
      end
      S_CHECK: begin
        if (op != KIND_MAX && val_rdata == val) begin
          state_next = (op == KIND_DELETE) ? S_UNLINK : S_FIN;
        end else begin
          state_next = S_WALK;
        end
      end
      S_UNLINK:   state_next = S_FREE;
      S_FREE:     state_next = S_FIN;
      S_FIN:      if (result_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    free_head_next   = free_head;
    fresh_count_next = fresh_count;
    ptr_next         = ptr;
    prev_next        = prev;
    cur_link_next    = cur_link;
    slot_next        = slot;
    bkt_k_next       = bkt_k;
    any_next         = any;
    best_next        = best;
    stat_next        = stat;
    res_next         = res;
    head_we          = 1'b0;
    head_clear       = 1'b0;
    head_waddr       = bkt;
    head_wdata       = NIL_PTR;
    mem_addr         = ptr[IDX_W-1:0];
    val_we           = 1'b0;
    link_we          = 1'b0;
    link_wdata       = free_head;
    result_load      = 1'b0;

    case (state)
      S_DISPATCH: begin
        stat_next = STAT_OK;
        res_next  = '0;
        prev_next = NIL_PTR;
        case (op)
          KIND_INSERT: begin
            if (free_head != NIL_PTR) begin
              mem_addr = free_head[IDX_W-1:0];
            end else if (fresh_count != NIL_PTR) begin
              slot_next        = fresh_count[IDX_W-1:0];
              fresh_count_next = fresh_count + PTR_W'(1);
            end else begin
              stat_next = STAT_FULL;
            end
          end
          KIND_SEARCH, KIND_DELETE: ptr_next = head[bkt];
          KIND_MAX: begin
            bkt_k_next = '0;
            any_next   = 1'b0;
            best_next  = '0;
            ptr_next   = head[0];
          end
          KIND_CLEAR: begin
            head_clear       = 1'b1;
            free_head_next   = NIL_PTR;
            fresh_count_next = '0;
          end
          default: ;
        endcase
      end
      // pop the free list
      S_ALLOC: begin
        slot_next      = free_head[IDX_W-1:0];
        free_head_next = link_rdata;
      end
      // new entry at the chain head
      S_INS_WR: begin
        mem_addr   = slot;
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = head[bkt];
        head_we    = 1'b1;
        head_wdata = {1'b0, slot};
      end
      S_WALK: begin
        if (ptr == NIL_PTR) begin
          if (op == KIND_MAX) begin
            if (bkt_k == BKT_W'(BUCKETS - 1)) begin
              stat_next = any ? STAT_OK : STAT_EMPTY;
              res_next  = best;
            end else begin
              bkt_k_next = bkt_k + BKT_W'(1);
              ptr_next   = head[bkt_k + BKT_W'(1)];
            end
          end else begin
            stat_next = STAT_MISS;
          end
        end
      end
      S_CHECK: begin
        if (op == KIND_MAX) begin
          if (!any || val_rdata > best) best_next = val_rdata;
          any_next = 1'b1;
          ptr_next = link_rdata;
        end else if (val_rdata == val) begin
          res_next      = val;
          cur_link_next = link_rdata;
        end else begin
          prev_next = ptr;
          ptr_next  = link_rdata;
        end
      end
      // bypass the found node
      S_UNLINK: begin
        if (prev == NIL_PTR) begin
          head_we    = 1'b1;
          head_wdata = cur_link;
        end else begin
          mem_addr   = prev[IDX_W-1:0];
          link_we    = 1'b1;
          link_wdata = cur_link;
        end
      end
      // push the node onto the free list
      S_FREE: begin
        link_we        = 1'b1;
        link_wdata     = free_head;
        free_head_next = ptr;
      end
      S_FIN: result_load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= NIL_PTR;
      fresh_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      fresh_count <= fresh_count_next;
      if (result_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (rst || head_clear) begin
      for (int i = 0; i < BUCKETS; i++) head[i] <= NIL_PTR;
    end else if (head_we) begin
      head[head_waddr] <= head_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      op  <= kind;
      val <= item_value;
    end
    ptr      <= ptr_next;
    prev     <= prev_next;
    cur_link <= cur_link_next;
    slot     <= slot_next;
    bkt_k    <= bkt_k_next;
    any      <= any_next;
    best     <= best_next;
    stat     <= stat_next;
    res      <= res_next;
    if (result_load) begin
      status       <= stat;
      result_value <= res;
    end
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_take |=> item_stall)
    else $error("input not stalled after item taken");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= NIL_PTR)
    else $error("fresh slot count beyond pool size");

  a_check_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_WALK)
    else $error("node compare without memory read");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    result_load |-> state == S_FIN && (!result_valid || !result_stall))
    else $error("result register overwritten while full");

endmodule

// ===== dv/chained_hash_table_top_test.sv =====
module chained_hash_table_top_test;
  import chp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]       kind;
    logic [VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
  } res_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic [2:0]       kind = '0;
  logic [VAL_W-1:0] item_value = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [1:0]       status;
  logic [VAL_W-1:0] result_value;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors = 0;
  int   send_idle_pct = 17;
  int   recv_idle_pct = 52;
  bit   hold_send = 1'b0;

  // shadow copy of the table
  logic [PTR_W-1:0] sh_head[BUCKETS];
  logic [VAL_W-1:0] sh_value[POOL_ENTRIES];
  logic [PTR_W-1:0] sh_link[POOL_ENTRIES];
  logic [PTR_W-1:0] sh_free;
  int               sh_fresh;

  chained_hash_table_top u_top (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void table_clear();
    for (int b = 0; b < BUCKETS; b++) sh_head[b] = NIL_PTR;
    sh_free  = NIL_PTR;
    sh_fresh = 0;
  endfunction

  // compute the result of one item and update the shadow table
  function automatic res_t table_apply(op_t op);
    res_t             r;
    logic [BKT_W-1:0] b;
    logic [PTR_W-1:0] p, prev, s;
    bit               found, any;
    int               steps;
    r = '0;
    b = op.value[BKT_W-1:0];
    case (op.kind)
      KIND_INSERT: begin
        s = NIL_PTR;
        if (sh_free != NIL_PTR) begin
          s = sh_free;
          sh_free = sh_link[s[IDX_W-1:0]];
        end else if (sh_fresh < POOL_ENTRIES) begin
          s = PTR_W'(sh_fresh);
          sh_fresh++;
        end
        if (s == NIL_PTR) r.status = STAT_FULL;
        else begin
          sh_value[s[IDX_W-1:0]] = op.value;
          sh_link[s[IDX_W-1:0]]  = sh_head[b];
          sh_head[b]             = s;
        end
      end
      KIND_SEARCH, KIND_DELETE: begin
        found = 1'b0;
        p = sh_head[b];
        prev = NIL_PTR;
        steps = 0;
        while (p < NIL_PTR && steps < POOL_ENTRIES && !found) begin
          if (sh_value[p[IDX_W-1:0]] == op.value) found = 1'b1;
          else begin
            prev = p;
            p = sh_link[p[IDX_W-1:0]];
            steps++;
          end
        end
        if (!found) r.status = STAT_MISS;
        else begin
          r.value = op.value;
          if (op.kind == KIND_DELETE) begin
            if (prev == NIL_PTR) sh_head[b] = sh_link[p[IDX_W-1:0]];
            else sh_link[prev[IDX_W-1:0]] = sh_link[p[IDX_W-1:0]];
            sh_link[p[IDX_W-1:0]] = sh_free;
            sh_free = p;
          end
        end
      end
      KIND_MAX: begin
        any = 1'b0;
        for (int k = 0; k < BUCKETS; k++) begin
          p = sh_head[k];
          steps = 0;
          while (p < NIL_PTR && steps < POOL_ENTRIES) begin
            if (!any || sh_value[p[IDX_W-1:0]] > r.value) r.value = sh_value[p[IDX_W-1:0]];
            any = 1'b1;
            p = sh_link[p[IDX_W-1:0]];
            steps++;
          end
        end
        if (!any) r.status = STAT_EMPTY;
      end
      KIND_CLEAR: table_clear();
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (!item_valid || !item_stall) begin
        if (pending_ops.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          op_t op;
          op = pending_ops.pop_front();
          item_valid <= 1'b1;
          kind       <= op.kind;
          item_value <= op.value;
          expected_results.push_back(table_apply(op));
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d value %0d", $time, status,
                 result_value);
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (result_value !== e.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time, e.value,
                   result_value);
          errors++;
        end
      end
    end
  end

  function automatic op_t rand_op(int vmax);
    op_t op;
    int  r;
    r = $urandom_range(99);
    op.kind = (r < 45) ? KIND_INSERT : (r < 65) ? KIND_SEARCH :
              (r < 88) ? KIND_DELETE : (r < 96) ? KIND_MAX :
              (r < 97) ? KIND_CLEAR : 3'($urandom_range(7, 5));
    if ($urandom_range(9) == 0) op.value = VAL_W'($urandom);
    else op.value = VAL_W'($urandom_range(vmax));
    return op;
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || item_valid)
      @(posedge clk);
  endtask

  // stimulus
  initial begin
    op_t op;
    table_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicates, unused kinds
    pending_ops.push_back('{KIND_MAX, 0});
    pending_ops.push_back('{KIND_SEARCH, 5});
    pending_ops.push_back('{KIND_DELETE, 5});
    pending_ops.push_back('{KIND_INSERT, 0});
    pending_ops.push_back('{KIND_INSERT, {VAL_W{1'b1}}});
    pending_ops.push_back('{KIND_INSERT, 16});
    pending_ops.push_back('{KIND_INSERT, 16});
    pending_ops.push_back('{KIND_MAX, 0});
    pending_ops.push_back('{KIND_SEARCH, {VAL_W{1'b1}}});
    pending_ops.push_back('{KIND_DELETE, 16});
    pending_ops.push_back('{KIND_SEARCH, 16});
    pending_ops.push_back('{KIND_DELETE, 16});
    pending_ops.push_back('{KIND_DELETE, 16});
    pending_ops.push_back('{KIND_DELETE, 0});
    pending_ops.push_back('{KIND_INSERT, 32});
    pending_ops.push_back('{3'd5, {VAL_W{1'b1}}});
    pending_ops.push_back('{3'd6, 0});
    pending_ops.push_back('{3'd7, 1});
    pending_ops.push_back('{KIND_CLEAR, 0});
    pending_ops.push_back('{KIND_MAX, 0});
    drain();

    // fill the pool past full, then reuse freed slots
    for (int i = 0; i < POOL_ENTRIES + 2; i++)
      pending_ops.push_back('{KIND_INSERT, VAL_W'($urandom_range(300))});
    for (int i = 0; i < 20; i++)
      pending_ops.push_back('{KIND_DELETE, VAL_W'($urandom_range(300))});
    for (int i = 0; i < 10; i++)
      pending_ops.push_back('{KIND_INSERT, VAL_W'($urandom)});
    pending_ops.push_back('{KIND_MAX, 0});
    pending_ops.push_back('{KIND_CLEAR, 0});
    // sender holds off until the table has answered everything
    drain();
    hold_send = 1'b1;
    repeat (3) @(posedge clk);
    hold_send = 1'b0;

    // random phases with swapped idling, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 17 : 0;
      for (int i = 0; i < 330; i++) begin
        op = rand_op(63);
        pending_ops.push_back(op);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/chp_pkg.sv
rtl/chp_ram.sv
rtl/chained_hash_table_top.sv
dv/chained_hash_table_top_test.sv
